>>> hw/rtl/fnc_pkg.sv
// ----------------------------------------------------------------------------
// fnc_pkg: shared constants for the factor nesting check
// Field widths of the stream words, default sizes and the pass epoch width.
// ----------------------------------------------------------------------------
package fnc_pkg;

  localparam int unsigned LEVEL_W          = 12;    // fe_level field
  localparam int unsigned CLUSTER_W        = 24;    // cluster_id field
  localparam int unsigned IN_TDATA_W       = 40;    // 36 bits rounded up to bytes
  localparam int unsigned OUT_TDATA_W      = 8;     // nested, rounded up to a byte

  localparam int unsigned FE_LEVELS_DEF    = 4096;
  localparam int unsigned CLUSTER_BITS_DEF = 24;

  // Pass tag kept beside each entry; tag zero marks a cleared entry.
  localparam int unsigned EPOCH_BITS       = 8;

endpackage

>>> hw/rtl/factor_nesting_check_core.sv
// ----------------------------------------------------------------------------
// factor_nesting_check_core: checks that each factor level maps to one cluster
// Streams (level, cluster) words and reports per pass whether nesting holds.
// ----------------------------------------------------------------------------
// Each input word carries a factor level and a cluster id; tlast closes a
// pass. A table in RAM keeps the first cluster seen per level; a later word
// with the same level and a different cluster sets a sticky conflict flag.
// The word carrying tlast is checked like any other, then one output word
// is sent: nested = 1 if the pass had no conflict. Levels at or above
// FE_LEVELS are ignored by the table, and only the low CLUSTER_BITS bits of
// the cluster id are stored and compared. Throughput is one word per cycle
// outside the stalls below: the table read is issued on accept, compared in
// the compare stage and written back in the same cycle, with a bypass for a
// word hitting the level written just before it. Entries carry an 8-bit pass
// tag instead of a valid bit, so a new pass starts with no clearing. After
// reset, and after every 255th pass when the tag wraps, the block sweeps the
// whole table with tready low. A tlast word also waits while an earlier
// result is still unread on the output.
// ----------------------------------------------------------------------------
module factor_nesting_check_core
  import fnc_pkg::*;
#(
  parameter int unsigned FE_LEVELS    = FE_LEVELS_DEF,
  parameter int unsigned CLUSTER_BITS = CLUSTER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // tdata: fe_level [11:0], cluster_id [35:12], zero pad [39:36]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,   // is_last
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: nested [0], zero pad [7:1]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  localparam int unsigned AW      = $clog2(FE_LEVELS);
  localparam int unsigned ENTRY_W = EPOCH_BITS + CLUSTER_BITS;

  typedef struct packed {
    logic [EPOCH_BITS-1:0]   epoch;
    logic [CLUSTER_BITS-1:0] cluster;
  } entry_t;

  // Input word fields
  logic [LEVEL_W-1:0]      in_level;
  logic [CLUSTER_W-1:0]    in_cluster_raw;
  logic [AW-1:0]           in_addr;
  logic                    in_range;
  logic                    in_accept;

  assign in_level       = s_axis_tdata[LEVEL_W-1:0];
  assign in_cluster_raw = s_axis_tdata[LEVEL_W+CLUSTER_W-1:LEVEL_W];
  assign in_addr        = AW'(in_level);
  assign in_range       = 32'(in_level) < 32'(FE_LEVELS);
  assign in_accept      = s_axis_tvalid && s_axis_tready;

  // Control state
  logic                    clearing;
  logic [AW-1:0]           sweep;
  logic [EPOCH_BITS-1:0]   epoch;
  logic                    conflict_seen;

  // Compare stage (word whose table read is returning)
  logic                    s1_valid;
  logic                    s1_range;
  logic                    s1_last;
  logic [AW-1:0]           s1_addr;
  logic [CLUSTER_BITS-1:0] s1_cluster;
  logic                    fwd_hit;
  entry_t                  fwd_data;

  // Output register
  logic                    out_valid;
  logic                    out_nested;

  // RAM ports
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  entry_t                  wr_data;
  logic [ENTRY_W-1:0]      rd_data;

  entry_t                  cur;
  logic                    seen;
  logic                    hit_conflict;
  logic                    s1_go;
  logic                    epoch_max;

  assign epoch_max = (epoch == '1);

  // Entry as of now: bypass the write made in the read cycle
  assign cur          = fwd_hit ? fwd_data : entry_t'(rd_data);
  assign seen         = (cur.epoch == epoch);
  assign hit_conflict = s1_range && seen && (cur.cluster != s1_cluster);

  // A tlast word needs a free output register; others always move on
  assign s1_go = s1_valid && (!s1_last || !out_valid || m_axis_tready);

  assign s_axis_tready = !clearing && (!s1_valid || s1_go)
                         && !(s1_valid && s1_last && epoch_max);

  // Table writes: sweep, or first sighting of a level in this pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr;
    wr_data = '{epoch: epoch, cluster: s1_cluster};
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = '0;
    end else if (s1_go && s1_range && !seen) begin
      wr_en   = 1'b1;
    end
  end

  fnc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FE_LEVELS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ENTRY_W'(wr_data)),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      sweep         <= '0;
      epoch         <= EPOCH_BITS'(1);
      conflict_seen <= 1'b0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // clearing sweep
      if (clearing) begin
        sweep <= sweep + AW'(1);
        if (sweep == AW'(FE_LEVELS - 1)) begin
          clearing <= 1'b0;
        end
      end

      // output register: a retiring tlast word refills it
      if (s1_go && s1_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // compare stage retires
      if (s1_go) begin
        if (s1_last) begin
          out_nested    <= !(conflict_seen || hit_conflict);
          conflict_seen <= 1'b0;
          if (epoch_max) begin
            epoch    <= EPOCH_BITS'(1);
            clearing <= 1'b1;
            sweep    <= '0;
          end else begin
            epoch <= epoch + EPOCH_BITS'(1);
          end
        end else begin
          conflict_seen <= conflict_seen || hit_conflict;
        end
      end

      // compare stage loads
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end

    // payload, no reset
    if (in_accept) begin
      s1_range   <= in_range;
      s1_last    <= s_axis_tlast;
      s1_addr    <= in_addr;
      s1_cluster <= CLUSTER_BITS'(in_cluster_raw);
      fwd_hit    <= wr_en && (wr_addr == in_addr);
      fwd_data   <= wr_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_nested};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("word accepted during table sweep");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (clearing || s1_go))
    else $error("table write without sweep or retiring word");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> !conflict_seen)
    else $error("conflict flag not cleared after pass end");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("pass tag reached cleared-entry value");

  a_stall_last_only: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (s1_last && out_valid && !m_axis_tready))
    else $error("compare stage stalled without pending result");

endmodule

>>> hw/rtl/fnc_ram.sv
// ----------------------------------------------------------------------------
// fnc_ram: simple dual-port RAM
// One write port, one read port with read enable and registered read data.
// Read during write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module fnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/sv/nesting_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// nesting_scoreboard_pkg: expected-result tracking for the factor nesting check
// Keeps its own level table and conflict flag, predicts one nested bit per
// closed pass and checks output words against those predictions in order.
// ----------------------------------------------------------------------------
package nesting_scoreboard_pkg;

  import fnc_pkg::*;

  class nesting_scoreboard;

    localparam logic [CLUSTER_W-1:0] CLUSTER_MASK =
      CLUSTER_W'((64'd1 << CLUSTER_BITS_DEF) - 64'd1);

    bit                   level_known [FE_LEVELS_DEF];
    logic [CLUSTER_W-1:0] first_cluster [FE_LEVELS_DEF];
    bit                   pass_conflict;
    bit                   expected_nested [$];

    int errors;
    int words;
    int passes;
    int nested_results;
    int conflict_results;

    function new();
      errors = 0;
      words = 0;
      passes = 0;
      nested_results = 0;
      conflict_results = 0;
      clear_pass();
    endfunction

    function void clear_pass();
      foreach (level_known[i]) begin
        level_known[i] = 1'b0;
        first_cluster[i] = '0;
      end
      pass_conflict = 1'b0;
    endfunction

    // Accepted input word: update the table, close the pass on last.
    function void note_word(logic [LEVEL_W-1:0] level, logic [CLUSTER_W-1:0] cluster,
                            bit last);
      logic [CLUSTER_W-1:0] kept;
      kept = cluster & CLUSTER_MASK;
      words++;
      if (int'(level) < FE_LEVELS_DEF) begin
        if (!level_known[level]) begin
          level_known[level] = 1'b1;
          first_cluster[level] = kept;
        end else if (first_cluster[level] != kept) begin
          pass_conflict = 1'b1;
        end
      end
      if (last) begin
        expected_nested.insert(expected_nested.size(), !pass_conflict);
        passes++;
        if (pass_conflict) conflict_results++;
        else nested_results++;
        clear_pass();
      end
    endfunction

    // Accepted output word: compare with the oldest closed pass.
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      bit want;
      if (expected_nested.size() == 0) begin
        $error("nested: unexpected output word 0x%0h with no pass closed", tdata);
        errors++;
        return;
      end
      want = expected_nested.pop_front();
      if (tdata[0] !== want) begin
        $error("nested: expected %0d, got %0b", want, tdata[0]);
        errors++;
      end
      if (tdata[OUT_TDATA_W-1:1] !== '0) begin
        $error("pad: expected 0, got 0x%0h", tdata[OUT_TDATA_W-1:1]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_nested.size();
    endfunction

  endclass

endpackage

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of factor_nesting_check_core
// Directed passes for table extremes, reuse and conflicts, then several
// hundred random passes under varying idle and stall patterns, enough to
// wrap the pass tag; every output word is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import fnc_pkg::*;
  import nesting_scoreboard_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 900;
  localparam int RANDOM_PASSES = 250;   // with the directed ones, past a tag wrap

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  nesting_scoreboard sb;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int input_stalls = 0;

  always #5 clk = ~clk;

  factor_nesting_check_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // Offer one word, with random idle cycles ahead of it, and wait for accept.
  task automatic send_word(input logic [LEVEL_W-1:0] level,
                           input logic [CLUSTER_W-1:0] cluster, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {{(IN_TDATA_W - LEVEL_W - CLUSTER_W){1'b0}}, cluster, level};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    sb.note_word(level, cluster, last);
  endtask

  // One pass. Clusters follow a per-pass mapping of the level, so the pass
  // is nested unless err_pct flips a cluster bit. hot keeps most levels in
  // a small window so entries from earlier passes get hit again.
  task automatic send_pass(input int len, input int err_pct,
                           input logic [CLUSTER_W-1:0] salt, input bit hot);
    logic [LEVEL_W-1:0]   level;
    logic [CLUSTER_W-1:0] cluster;
    for (int i = 0; i < len; i++) begin
      if (hot && $urandom_range(0, 99) < 70) level = LEVEL_W'($urandom_range(0, 31));
      else level = LEVEL_W'($urandom_range(0, 4095));
      cluster = salt + CLUSTER_W'(level) * CLUSTER_W'(24'h003b1d);
      if ($urandom_range(0, 99) < err_pct)
        cluster ^= CLUSTER_W'(1) << $urandom_range(0, CLUSTER_W - 1);
      send_word(level, cluster, i == len - 1);
    end
  endtask

  // Stop offering and wait until every closed pass has reported.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Output side: check accepted words, stall at random, and serve a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
        if (hold_left == 0) hold_served++;
      end else if (hold_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase;
    int pick;
    int len;
    int err_pct;
    int rand_passes;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, back to back. The block sweeps its table after reset, so
    // the first word simply waits for tready.
    send_word(12'd0, 24'h000000, 1'b1);                      // single-word pass
    send_word(12'hfff, 24'hffffff, 1'b0);                    // top level, top id
    send_word(12'hfff, 24'hffffff, 1'b0);
    send_word(12'd0, 24'h000000, 1'b1);                      // nested
    send_word(12'hfff, 24'h000000, 1'b0);
    send_word(12'hfff, 24'hffffff, 1'b0);                    // conflict
    send_word(12'd5, 24'h000001, 1'b0);                      // new level after it
    send_word(12'd5, 24'h000001, 1'b1);                      // still not nested
    send_word(12'd7, 24'h123456, 1'b0);
    send_word(12'd7, 24'h123457, 1'b1);                      // last word conflicts
    send_word(12'hfff, 24'h800000, 1'b0);                    // table cleared?
    send_word(12'd7, 24'h000000, 1'b1);
    send_word(12'd9, 24'h0a0a0a, 1'b0);                      // same level back to back
    send_word(12'd9, 24'h0a0a0a, 1'b0);
    send_word(12'd9, 24'h0a0a0b, 1'b1);
    send_word(12'd10, 24'h555555, 1'b0);
    send_word(12'd10, 24'h555555, 1'b0);
    send_word(12'd10, 24'h555555, 1'b1);
    drain();

    // Output held off for a long stretch while short passes keep coming,
    // so a pending result blocks the next tlast word.
    hold_requests++;
    for (int p = 0; p < 10; p++) send_pass(3, 20, CLUSTER_W'($urandom()), 1'b1);
    drain();

    // Random passes, mostly short so the pass tag wraps, in four idle phases.
    rand_passes = 0;
    phase = -1;
    while (sb.words < RANDOM_WORDS || rand_passes < RANDOM_PASSES) begin
      if (rand_passes * 4 / RANDOM_PASSES != phase && phase < 3) begin
        drain();
        phase++;
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
          default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(1, 2);
      else if (pick < 95) len = $urandom_range(3, 10);
      else len = $urandom_range(11, 32);
      case ($urandom_range(0, 3))
        0, 1: err_pct = 0;
        2: err_pct = 3;
        default: err_pct = 25;
      endcase
      send_pass(len, err_pct, CLUSTER_W'($urandom()), $urandom_range(0, 9) != 0);
      rand_passes++;
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d words in %0d passes: %0d nested, %0d with a conflict",
             sb.words, sb.passes, sb.nested_results, sb.conflict_results);
    $display("input held off for %0d cycles, including sweeps and a %0d-cycle output hold",
             input_stalls, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
